// File: design/escaped_frame_command_decoder_macros.svh
// Assertion helpers used by the decoder back stage (efcd_back).
`ifndef ESCAPED_FRAME_COMMAND_DECODER_MACROS_SVH
`define ESCAPED_FRAME_COMMAND_DECODER_MACROS_SVH

// Clocked check, skipped while reset is high.
`define EFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define EFCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/efcd_pkg.sv
package efcd_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int ARG_BYTES   = 32;
  localparam int FUNC_COUNT  = 13;

  localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int ARG_IDX_W   = $clog2(ARG_BYTES);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = 56;

  localparam logic [7:0] BYTE_END      = 8'd0;
  localparam logic [7:0] BYTE_ESC      = 8'd92;
  localparam logic [7:0] CODE_SET_ARGS = 8'd1;
  localparam logic [7:0] CODE_EXEC     = 8'd2;

  typedef enum logic {
    ITEM_STORE,
    ITEM_END
  } item_kind_t;

  typedef struct packed {
    item_kind_t             kind;
    logic [7:0]             data;
    logic [FRAME_IDX_W-1:0] addr;
    logic [LEN_W-1:0]       length;
    logic                   overflow;
  } queue_item_t;

  typedef struct packed {
    logic [7:0]  cmd_code;
    logic        is_exec;
    logic        args_written;
    logic [3:0]  func_sel;
    logic [31:0] arg_word;
    logic [5:0]  frame_length;
    logic        overflowed;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CODE,
    BK_COPY,
    BK_IDX,
    BK_EMIT
  } back_state_t;

endpackage

// File: design/efcd_front.sv
module efcd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                q_full,
  output logic                push,
  output efcd_pkg::queue_item_t push_item
);

  logic                        escape_pending, escape_pending_next;
  logic [efcd_pkg::LEN_W-1:0]  fill_count, fill_count_next;
  logic                        overflow_seen, overflow_seen_next;
  logic                        accept;
  logic                        room;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign room     = (fill_count != efcd_pkg::LEN_W'(efcd_pkg::FRAME_BYTES));

  always_comb begin
    escape_pending_next = escape_pending;
    fill_count_next     = fill_count;
    overflow_seen_next  = overflow_seen;
    push                = 1'b0;
    push_item.kind      = efcd_pkg::ITEM_STORE;
    push_item.data      = s_tdata;
    push_item.addr      = fill_count[efcd_pkg::FRAME_IDX_W-1:0];
    push_item.length    = fill_count;
    push_item.overflow  = overflow_seen;
    if (accept) begin
      priority if (escape_pending || (s_tdata != efcd_pkg::BYTE_END &&
                                      s_tdata != efcd_pkg::BYTE_ESC)) begin
        // literal byte, escaped or plain
        escape_pending_next = 1'b0;
        if (room) begin
          push            = 1'b1;
          fill_count_next = fill_count + efcd_pkg::LEN_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end else if (s_tdata == efcd_pkg::BYTE_END) begin
        push               = 1'b1;
        push_item.kind     = efcd_pkg::ITEM_END;
        fill_count_next    = '0;
        overflow_seen_next = 1'b0;
      end else begin
        escape_pending_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      fill_count     <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
      fill_count     <= fill_count_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

// File: design/efcd_queue.sv
module efcd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  efcd_pkg::queue_item_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output efcd_pkg::queue_item_t pop_item
);

  efcd_pkg::queue_item_t       slots [efcd_pkg::QUEUE_DEPTH];
  logic [efcd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [efcd_pkg::QCNT_W-1:0] count;
  logic                        do_push, do_pop;

  assign full      = (count == efcd_pkg::QCNT_W'(efcd_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + efcd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + efcd_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + efcd_pkg::QCNT_W'(1);
        2'b01:   count <= count - efcd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/efcd_back.sv
`include "escaped_frame_command_decoder_macros.svh"

module efcd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  efcd_pkg::queue_item_t q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output efcd_pkg::result_t     m_result
);

  efcd_pkg::back_state_t state, state_next;

  logic [7:0]                       frame_mem [efcd_pkg::FRAME_BYTES];
  logic [7:0]                       rdata;
  logic [efcd_pkg::FRAME_IDX_W-1:0] rd_addr;
  logic                             mem_we;

  logic [7:0]                 arg_regs [efcd_pkg::ARG_BYTES];
  logic [efcd_pkg::LEN_W-1:0] len_r, len_m1, set_n, copy_n, cnt;
  logic                       ovf_r;
  logic [7:0]                 code_r, idx_r;
  logic                       out_valid, out_free, out_load;
  efcd_pkg::result_t          out_res;
  logic                       emit_stall, empty_end, emit_zero;

  assign out_free = !out_valid || m_tready;
  assign len_m1   = len_r - efcd_pkg::LEN_W'(1);

  // payload bytes to copy for a set-args frame, capped at the argument file size
  always_comb begin
    if (32'(len_m1) > efcd_pkg::ARG_BYTES) begin
      set_n = efcd_pkg::LEN_W'(efcd_pkg::ARG_BYTES);
    end else begin
      set_n = len_m1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      efcd_pkg::BK_IDLE: begin
        if (q_valid && q_item.kind == efcd_pkg::ITEM_END) begin
          state_next = (q_item.length == '0) ? efcd_pkg::BK_EMIT : efcd_pkg::BK_CODE;
        end
      end
      efcd_pkg::BK_CODE: begin
        priority if (rdata == efcd_pkg::CODE_SET_ARGS && set_n != '0) begin
          state_next = efcd_pkg::BK_COPY;
        end else if (rdata == efcd_pkg::CODE_EXEC && len_r >= efcd_pkg::LEN_W'(2)) begin
          state_next = efcd_pkg::BK_IDX;
        end else begin
          state_next = efcd_pkg::BK_EMIT;
        end
      end
      efcd_pkg::BK_COPY: begin
        if ((cnt + efcd_pkg::LEN_W'(1)) == copy_n) begin
          state_next = efcd_pkg::BK_EMIT;
        end
      end
      efcd_pkg::BK_IDX:  state_next = efcd_pkg::BK_EMIT;
      efcd_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = efcd_pkg::BK_IDLE;
        end
      end
      default: state_next = efcd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = '0;
    unique case (state)
      efcd_pkg::BK_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid && q_item.kind == efcd_pkg::ITEM_STORE;
      end
      efcd_pkg::BK_CODE: rd_addr = efcd_pkg::FRAME_IDX_W'(1);
      // one byte ahead: rdata in this cycle is frame byte cnt + 1
      efcd_pkg::BK_COPY: rd_addr = efcd_pkg::FRAME_IDX_W'(cnt + efcd_pkg::LEN_W'(2));
      efcd_pkg::BK_IDX:  rd_addr = '0;
      efcd_pkg::BK_EMIT: out_load = out_free;
      default:           rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[q_item.addr] <= q_item.data;
    end
    rdata <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < efcd_pkg::ARG_BYTES; i++) begin
        arg_regs[i] <= 8'd0;
      end
    end else if (state == efcd_pkg::BK_COPY) begin
      arg_regs[efcd_pkg::ARG_IDX_W'(cnt)] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efcd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.kind == efcd_pkg::ITEM_END) begin
      len_r  <= q_item.length;
      ovf_r  <= q_item.overflow;
      code_r <= 8'd0;
      idx_r  <= 8'd0;
    end
    if (state == efcd_pkg::BK_CODE) begin
      code_r <= rdata;
      copy_n <= set_n;
      cnt    <= '0;
    end
    if (state == efcd_pkg::BK_COPY) begin
      cnt <= cnt + efcd_pkg::LEN_W'(1);
    end
    if (state == efcd_pkg::BK_IDX) begin
      idx_r <= ({1'b0, rdata} < 9'(efcd_pkg::FUNC_COUNT)) ? rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res.cmd_code     <= code_r;
      out_res.is_exec      <= (code_r == efcd_pkg::CODE_EXEC);
      out_res.args_written <= (code_r == efcd_pkg::CODE_SET_ARGS);
      out_res.func_sel     <= idx_r[3:0];
      out_res.arg_word     <= {arg_regs[3], arg_regs[2], arg_regs[1], arg_regs[0]};
      out_res.frame_length <= 6'(len_r);
      out_res.overflowed   <= ovf_r;
    end
  end

  assign m_tvalid = out_valid;
  assign m_result = out_res;

  assign emit_stall = (state == efcd_pkg::BK_EMIT) && !out_free;
  assign empty_end  = q_pop && q_item.kind == efcd_pkg::ITEM_END && q_item.length == '0;
  assign emit_zero  = (state == efcd_pkg::BK_EMIT) && (code_r == 8'd0);

  `EFCD_ASSERT(a_copy_in_range, (state == efcd_pkg::BK_COPY) |-> (cnt < copy_n), "copy overrun")
  `EFCD_ASSERT(a_emit_holds, emit_stall |=> (state == efcd_pkg::BK_EMIT), "result dropped")
  `EFCD_ASSERT(a_empty_frame, empty_end |=> emit_zero, "empty frame not decoded as code 0")
  `EFCD_ASSERT_ALWAYS(a_pop_only_idle, q_pop |-> (state == efcd_pkg::BK_IDLE), "pop outside idle")

endmodule

// File: design/escaped_frame_command_decoder.sv
// Byte-stuffed frame command decoder. Received bytes enter on the s_ side; a backslash
// escapes the next byte and an unescaped NUL ends the frame, which then yields one result
// on the m_ side. A front stage classifies each byte and hands it through a four-entry
// queue to a back stage that keeps the frame memory and the argument file. Plain bytes
// are taken one per cycle while the queue has room. On a terminator the back stage goes
// from idle straight to emit for an empty frame; otherwise it reads the command code, then
// copies each argument byte of a set-args frame (up to 31) or reads the index byte of an
// execute frame, then emits, waiting while the output register holds an untaken result.
// The output register lets the next frame collect while a result waits to be taken.
module escaped_frame_command_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] cmd_code, [8] is_exec, [9] args_written, [13:10] func_sel,
  // [45:14] arg_word, [51:46] frame_length, [52] overflowed, [55:53] zero
  output logic [efcd_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic                  q_push, q_full, q_pop, q_valid;
  efcd_pkg::queue_item_t push_item, pop_item;
  efcd_pkg::result_t     result;

  efcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  efcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  efcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result)
  );

  assign m_tdata = {3'b000, result.overflowed, result.frame_length, result.arg_word,
                    result.func_sel, result.args_written, result.is_exec,
                    result.cmd_code};

endmodule
